// ----- hdl/lnq_pkg.sv -----
// Shared constants, codes and types of the lever notch quantizer.
`timescale 1ns / 1ps

package lnq_pkg;

    localparam int SAMPLE_BITS        = 10;
    localparam int LEVEL_W            = 10;
    localparam int STEP_W             = 6;
    localparam int FUNC_W             = 2;
    localparam int TIDX_W             = 5;
    localparam int REPORT_W           = 5;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 10;
    localparam int TABLE_DEPTH_DEF    = 32;
    localparam int WINDOW_SAMPLES_DEF = 100;

    localparam logic [LEVEL_W-1:0] FWD_LEVEL_RST     = 10'd1023;
    localparam logic [LEVEL_W-1:0] NEUTRAL_LEVEL_RST = 10'd512;
    localparam logic [LEVEL_W-1:0] REVERSE_LEVEL_RST = 10'd0;
    localparam logic [STEP_W-1:0]  STEPS_RST         = 6'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE   = 2'd0,
        FUNC_BRAKE_WR = 2'd1,
        FUNC_POWER_WR = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_REVERSER = 2'd0,
        KIND_BRAKE    = 2'd1,
        KIND_POWER    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REV_NEUTRAL = 2'd0,
        REV_BACK    = 2'd1,
        REV_FORWARD = 2'd2
    } t_rev;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_LEVEL     = 3'd0,
        CFG_NEUTRAL_LEVEL = 3'd1,
        CFG_REVERSE_LEVEL = 3'd2,
        CFG_BRAKE_STEPS   = 3'd3,
        CFG_POWER_STEPS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REV_FWD,
        ST_REV_BACK,
        ST_TBL_FIRST,
        ST_TBL_NEXT,
        ST_TBL_CMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic gt;
        logic lt;
    } t_cmp;

endpackage

// ----- hdl/lnq_in_if.sv -----
// Input item channel: sample triples and table loads.
`timescale 1ns / 1ps

interface lnq_in_if;
    logic                                valid;
    logic                                ready;
    logic [lnq_pkg::FUNC_W-1:0]          func;
    logic [lnq_pkg::SAMPLE_BITS-1:0]     reverser_sample;
    logic [lnq_pkg::SAMPLE_BITS-1:0]     power_sample;
    logic [lnq_pkg::SAMPLE_BITS-1:0]     brake_sample;
    logic [lnq_pkg::TIDX_W-1:0]          table_index;
    logic [lnq_pkg::LEVEL_W-1:0]         table_value;

    modport source (
        output valid, func, reverser_sample, power_sample, brake_sample,
               table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, func, reverser_sample, power_sample, brake_sample,
               table_index, table_value,
        output ready
    );
endinterface

// ----- hdl/lnq_out_if.sv -----
// Report channel: changed reverser position or notch.
`timescale 1ns / 1ps

interface lnq_out_if;
    logic                            valid;
    logic                            ready;
    lnq_pkg::t_kind                  report_kind;
    logic [lnq_pkg::REPORT_W-1:0]    report_value;
    logic                            last_report;

    modport source (
        output valid, report_kind, report_value, last_report,
        input  ready
    );
    modport sink (
        input  valid, report_kind, report_value, last_report,
        output ready
    );
endinterface

// ----- hdl/lnq_table_ram.sv -----
// Calibration table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module lnq_table_ram #(
    parameter int DEPTH = lnq_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(lnq_pkg::TABLE_DEPTH_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [lnq_pkg::LEVEL_W-1:0]  i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [lnq_pkg::LEVEL_W-1:0]  o_rdata
);

    logic [lnq_pkg::LEVEL_W-1:0] r_mem [DEPTH];
    logic [lnq_pkg::LEVEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lnq_thresh_unit.sv -----
// Shared threshold unit: midpoint of two levels, scale by window, compare with a sum.
`timescale 1ns / 1ps

module lnq_thresh_unit #(
    parameter int WINDOW_SAMPLES = lnq_pkg::WINDOW_SAMPLES_DEF,
    parameter int SUM_W          = 17
) (
    input  logic [lnq_pkg::LEVEL_W-1:0] i_from,
    input  logic [lnq_pkg::LEVEL_W-1:0] i_to,
    input  logic [SUM_W-1:0]            i_sum,
    output lnq_pkg::t_cmp               o_cmp
);

    localparam int LW     = lnq_pkg::LEVEL_W;
    localparam int PROD_W = LW + $clog2(WINDOW_SAMPLES + 1);
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    logic signed [LW:0] diff;
    logic signed [LW:0] half;
    logic signed [LW:0] mid_full;
    logic [LW-1:0]      mid;
    logic [PROD_W-1:0]  prod;
    logic [CMP_W-1:0]   sum_x;
    logic [CMP_W-1:0]   prod_x;

    always_comb begin
        diff     = $signed({1'b0, i_to}) - $signed({1'b0, i_from});
        // halve toward zero
        half     = (diff + $signed({{LW{1'b0}}, diff[LW]})) >>> 1;
        mid_full = $signed({1'b0, i_from}) + half;
        mid      = mid_full[LW-1:0];
        prod     = PROD_W'(mid) * PROD_W'(WINDOW_SAMPLES);
        sum_x    = CMP_W'(i_sum);
        prod_x   = CMP_W'(prod);
        o_cmp.gt = (sum_x > prod_x);
        o_cmp.lt = (sum_x < prod_x);
    end

endmodule

// ----- hdl/lever_notch_quantizer_core.sv -----
// Lever notch quantizer top level: window sums, sequencer and report output.
`timescale 1ns / 1ps

// Sample triples and table loads are each taken only while the block is idle.
// The sample that closes a window starts the classification walk, during which the
// input is not ready: first the two reverser thresholds, then for each table at most
// n-1 thresholds (n the clamped notch count), one table entry read per cycle
// from its memory and one threshold a cycle through the single midpoint, multiply
// and compare unit, ending early at the first matching notch window. Changed
// positions then leave on the report channel one per cycle while it is ready,
// reverser first, then brake, then power, the last one flagged.
module lever_notch_quantizer_core #(
    parameter int TABLE_DEPTH    = lnq_pkg::TABLE_DEPTH_DEF,
    parameter int WINDOW_SAMPLES = lnq_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lnq_in_if.sink                           i_item,
    lnq_out_if.source                        o_report,
    input  logic                             i_cfg_we,
    input  logic [lnq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lnq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_SAMPLES + 1);
    localparam int SUM_W   = lnq_pkg::SAMPLE_BITS + CNT_W;
    localparam int LW      = lnq_pkg::LEVEL_W;
    localparam int SW      = lnq_pkg::STEP_W;
    localparam int CLAMP_W = lnq_pkg::STEP_W + 1;
    localparam int RW      = lnq_pkg::REPORT_W;

    lnq_pkg::t_state  r_state, n_state;
    logic [LW-1:0]    r_fwd_level, r_neu_level, r_rev_level;
    logic [SW-1:0]    r_brake_steps, r_power_steps;
    logic [SUM_W-1:0] r_rev_sum, r_pwr_sum, r_brk_sum;
    logic [CNT_W-1:0] r_count;
    lnq_pkg::t_rev    r_rev_pos;
    logic [AW-1:0]    r_last_brk, r_last_pwr;
    logic             r_pend_rev, r_pend_brk, r_pend_pwr;
    logic             r_fwd_gt, r_fwd_lt;
    logic             r_sel;
    logic [AW-1:0]    r_idx;
    logic             r_flag;
    logic [LW-1:0]    r_prev;

    logic             item_xfer, report_xfer, is_sample, window_end;
    logic             brk_we, pwr_we;
    logic             idx_ok;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    rd_addr;
    logic [AW:0]      rd_addr_w;
    logic [LW-1:0]    brk_rdata, pwr_rdata, rd_data;
    logic [LW-1:0]    unit_from, unit_to;
    logic [SUM_W-1:0] unit_sum;
    lnq_pkg::t_cmp    cmp;
    logic [SW-1:0]    steps;
    logic [CLAMP_W-1:0] steps_x, clamped;
    logic [AW-1:0]    last_j, top_notch;
    logic             hit_a, keep_b, found, walk_done;
    logic [AW-1:0]    walk_notch;
    logic             pwr_change;

    assign item_xfer   = i_item.valid && i_item.ready;
    assign report_xfer = o_report.valid && o_report.ready;
    assign is_sample   = (lnq_pkg::t_func'(i_item.func) == lnq_pkg::FUNC_SAMPLE);
    assign window_end  = (r_count == CNT_W'(WINDOW_SAMPLES - 1));
    assign idx_ok      = (CLAMP_W'(i_item.table_index) < CLAMP_W'(TABLE_DEPTH));
    assign waddr       = AW'(i_item.table_index);
    assign brk_we      = item_xfer && idx_ok &&
                         (lnq_pkg::t_func'(i_item.func) == lnq_pkg::FUNC_BRAKE_WR);
    assign pwr_we      = item_xfer && idx_ok &&
                         (lnq_pkg::t_func'(i_item.func) == lnq_pkg::FUNC_POWER_WR);
    assign rd_data     = r_sel ? pwr_rdata : brk_rdata;

    lnq_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_brake_ram (
        .i_clk   (i_clk),
        .i_we    (brk_we),
        .i_waddr (waddr),
        .i_wdata (i_item.table_value),
        .i_raddr (rd_addr),
        .o_rdata (brk_rdata)
    );

    lnq_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (pwr_we),
        .i_waddr (waddr),
        .i_wdata (i_item.table_value),
        .i_raddr (rd_addr),
        .o_rdata (pwr_rdata)
    );

    lnq_thresh_unit #(.WINDOW_SAMPLES(WINDOW_SAMPLES), .SUM_W(SUM_W)) u_thresh (
        .i_from (unit_from),
        .i_to   (unit_to),
        .i_sum  (unit_sum),
        .o_cmp  (cmp)
    );

    // notch window walk
    always_comb begin
        steps   = r_sel ? r_power_steps : r_brake_steps;
        steps_x = CLAMP_W'(steps);
        priority if (steps_x < CLAMP_W'(2)) begin
            clamped = CLAMP_W'(2);
        end else if (steps_x > CLAMP_W'(TABLE_DEPTH)) begin
            clamped = CLAMP_W'(TABLE_DEPTH);
        end else begin
            clamped = steps_x;
        end
        last_j     = AW'(clamped - CLAMP_W'(2));
        top_notch  = AW'(clamped - CLAMP_W'(1));
        hit_a      = r_sel ? cmp.gt : cmp.lt;
        keep_b     = r_sel ? cmp.lt : cmp.gt;
        found      = (r_idx == '0) ? hit_a : (r_flag && hit_a);
        walk_done  = found || (r_idx == last_j);
        walk_notch = found ? r_idx : top_notch;
        pwr_change = (walk_notch != r_last_pwr);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lnq_pkg::ST_IDLE: begin
                if (item_xfer && is_sample && window_end) begin
                    n_state = lnq_pkg::ST_REV_FWD;
                end
            end
            lnq_pkg::ST_REV_FWD:   n_state = lnq_pkg::ST_REV_BACK;
            lnq_pkg::ST_REV_BACK:  n_state = lnq_pkg::ST_TBL_FIRST;
            lnq_pkg::ST_TBL_FIRST: n_state = lnq_pkg::ST_TBL_NEXT;
            lnq_pkg::ST_TBL_NEXT:  n_state = lnq_pkg::ST_TBL_CMP;
            lnq_pkg::ST_TBL_CMP: begin
                if (walk_done) begin
                    if (!r_sel) begin
                        n_state = lnq_pkg::ST_TBL_FIRST;
                    end else if (r_pend_rev || r_pend_brk || pwr_change) begin
                        n_state = lnq_pkg::ST_EMIT;
                    end else begin
                        n_state = lnq_pkg::ST_IDLE;
                    end
                end
            end
            lnq_pkg::ST_EMIT: begin
                if (report_xfer && o_report.last_report) begin
                    n_state = lnq_pkg::ST_IDLE;
                end
            end
            default: n_state = lnq_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath selects
    always_comb begin
        i_item.ready = (r_state == lnq_pkg::ST_IDLE);
        o_report.valid = (r_state == lnq_pkg::ST_EMIT);
        priority if (r_pend_rev) begin
            o_report.report_kind  = lnq_pkg::KIND_REVERSER;
            o_report.report_value = RW'(r_rev_pos);
            o_report.last_report  = !(r_pend_brk || r_pend_pwr);
        end else if (r_pend_brk) begin
            o_report.report_kind  = lnq_pkg::KIND_BRAKE;
            o_report.report_value = RW'(r_last_brk);
            o_report.last_report  = !r_pend_pwr;
        end else begin
            o_report.report_kind  = lnq_pkg::KIND_POWER;
            o_report.report_value = RW'(r_last_pwr);
            o_report.last_report  = 1'b1;
        end

        rd_addr_w = '0;
        unit_from = '0;
        unit_to   = '0;
        unit_sum  = '0;
        unique case (r_state)
            lnq_pkg::ST_REV_FWD: begin
                unit_from = r_neu_level;
                unit_to   = r_fwd_level;
                unit_sum  = r_rev_sum;
            end
            lnq_pkg::ST_REV_BACK: begin
                unit_from = r_neu_level;
                unit_to   = r_rev_level;
                unit_sum  = r_rev_sum;
            end
            lnq_pkg::ST_TBL_NEXT: begin
                rd_addr_w = (AW + 1)'(1);
            end
            lnq_pkg::ST_TBL_CMP: begin
                rd_addr_w = {1'b0, r_idx} + (AW + 1)'(2);
                unit_from = r_sel ? rd_data : r_prev;
                unit_to   = r_sel ? r_prev : rd_data;
                unit_sum  = r_sel ? r_pwr_sum : r_brk_sum;
            end
            default: begin
                rd_addr_w = '0;
            end
        endcase
        rd_addr = rd_addr_w[AW-1:0];
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lnq_pkg::ST_IDLE;
            r_fwd_level   <= lnq_pkg::FWD_LEVEL_RST;
            r_neu_level   <= lnq_pkg::NEUTRAL_LEVEL_RST;
            r_rev_level   <= lnq_pkg::REVERSE_LEVEL_RST;
            r_brake_steps <= lnq_pkg::STEPS_RST;
            r_power_steps <= lnq_pkg::STEPS_RST;
            r_rev_sum     <= '0;
            r_pwr_sum     <= '0;
            r_brk_sum     <= '0;
            r_count       <= '0;
            r_rev_pos     <= lnq_pkg::REV_NEUTRAL;
            r_last_brk    <= '0;
            r_last_pwr    <= '0;
            r_pend_rev    <= 1'b0;
            r_pend_brk    <= 1'b0;
            r_pend_pwr    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (lnq_pkg::t_cfg_idx'(i_cfg_index))
                    lnq_pkg::CFG_FWD_LEVEL:     r_fwd_level   <= i_cfg_data[LW-1:0];
                    lnq_pkg::CFG_NEUTRAL_LEVEL: r_neu_level   <= i_cfg_data[LW-1:0];
                    lnq_pkg::CFG_REVERSE_LEVEL: r_rev_level   <= i_cfg_data[LW-1:0];
                    lnq_pkg::CFG_BRAKE_STEPS:   r_brake_steps <= i_cfg_data[SW-1:0];
                    lnq_pkg::CFG_POWER_STEPS:   r_power_steps <= i_cfg_data[SW-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == lnq_pkg::ST_IDLE && item_xfer && is_sample) begin
                r_rev_sum <= r_rev_sum + SUM_W'(i_item.reverser_sample);
                r_pwr_sum <= r_pwr_sum + SUM_W'(i_item.power_sample);
                r_brk_sum <= r_brk_sum + SUM_W'(i_item.brake_sample);
                r_count   <= r_count + CNT_W'(1);
            end

            if (r_state == lnq_pkg::ST_REV_BACK) begin
                priority if (r_fwd_gt && r_rev_pos != lnq_pkg::REV_FORWARD) begin
                    r_rev_pos  <= lnq_pkg::REV_FORWARD;
                    r_pend_rev <= 1'b1;
                end else if (cmp.lt && r_rev_pos != lnq_pkg::REV_BACK) begin
                    r_rev_pos  <= lnq_pkg::REV_BACK;
                    r_pend_rev <= 1'b1;
                end else if (cmp.gt && r_fwd_lt && r_rev_pos != lnq_pkg::REV_NEUTRAL) begin
                    r_rev_pos  <= lnq_pkg::REV_NEUTRAL;
                    r_pend_rev <= 1'b1;
                end else begin
                    r_pend_rev <= 1'b0;
                end
            end

            if (r_state == lnq_pkg::ST_TBL_CMP && walk_done) begin
                if (!r_sel) begin
                    if (walk_notch != r_last_brk) begin
                        r_last_brk <= walk_notch;
                        r_pend_brk <= 1'b1;
                    end
                end else if (pwr_change) begin
                    r_last_pwr <= walk_notch;
                    r_pend_pwr <= 1'b1;
                end
            end

            if (r_state == lnq_pkg::ST_EMIT && report_xfer) begin
                priority if (r_pend_rev) begin
                    r_pend_rev <= 1'b0;
                end else if (r_pend_brk) begin
                    r_pend_brk <= 1'b0;
                end else begin
                    r_pend_pwr <= 1'b0;
                end
            end

            // close the window
            if (r_state != lnq_pkg::ST_IDLE && n_state == lnq_pkg::ST_IDLE) begin
                r_rev_sum <= '0;
                r_pwr_sum <= '0;
                r_brk_sum <= '0;
                r_count   <= '0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lnq_pkg::ST_REV_FWD: begin
                r_fwd_gt <= cmp.gt;
                r_fwd_lt <= cmp.lt;
            end
            lnq_pkg::ST_REV_BACK: begin
                r_sel <= 1'b0;
            end
            lnq_pkg::ST_TBL_FIRST: begin
                r_idx  <= '0;
                r_flag <= 1'b0;
            end
            lnq_pkg::ST_TBL_NEXT: begin
                r_prev <= rd_data;
            end
            lnq_pkg::ST_TBL_CMP: begin
                r_prev <= rd_data;
                r_flag <= keep_b;
                r_idx  <= r_idx + AW'(1);
                if (walk_done) begin
                    r_sel <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && o_report.valid))
        else $error("input taken while reports pending");

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report.valid |-> (r_pend_rev || r_pend_brk || r_pend_pwr))
        else $error("report shown with nothing pending");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (report_xfer && o_report.last_report) |=>
            (r_state == lnq_pkg::ST_IDLE && r_count == '0 && r_brk_sum == '0))
        else $error("window not closed after last report");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lnq_pkg::ST_TBL_CMP) |-> (r_idx <= last_j))
        else $error("table walk past last threshold");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lnq_pkg::ST_IDLE) |-> (r_count < CNT_W'(WINDOW_SAMPLES)))
        else $error("sample count reached window while idle");

endmodule
